// ===== rtl/ppu_pkg.sv =====
// Shared types, codes and constants of the palette pixel unpacker.
`default_nettype none
package ppu_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF  = 256;
  localparam int unsigned MAX_INDEX_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned BPP_W      = 5;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned PEND_W     = 5;
  localparam int unsigned EXT_W      = 17;

  localparam logic [BPP_W-1:0]  BPP_RESET   = 5'd8;
  localparam logic [PEND_W-1:0] PEND_MAX    = 5'd31;
  localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME = 2'd2;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_DATA    = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_BITS
  } ppu_state_e;

  typedef struct packed {
    logic                 wr_pal;
    logic                 load_byte;
    logic                 step;
    logic [BIT_IDX_W-1:0] bit_idx;
  } ppu_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
  } ppu_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ppu_ctrl.sv =====
// Controller: input handshake and per-bit sequencing of a data byte.
`default_nettype none
module ppu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              req_type_i,
  input  wire ppu_pkg::ppu_stat_t stat_i,
  output ppu_pkg::ppu_cmd_t      cmd_o
);
  import ppu_pkg::*;

  ppu_state_e           state_q, state_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d           = state_q;
    bit_d             = bit_q;
    cmd_o.wr_pal      = 1'b0;
    cmd_o.load_byte   = 1'b0;
    cmd_o.step        = 1'b0;
    cmd_o.bit_idx     = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_DATA) begin
            cmd_o.load_byte = 1'b1;
            bit_d           = '1;
            state_d         = S_BITS;
          end else begin
            cmd_o.wr_pal = 1'b1;
          end
        end
      end
      S_BITS: begin
        if (stat_i.frame_done) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.step = 1'b1;
          if (bit_q == '0) begin
            state_d = S_IDLE;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ppu_datapath.sv =====
// Datapath: config registers, bit accumulator, palette memory, output register.
`default_nettype none
module ppu_datapath #(
  parameter int unsigned PALETTE_DEPTH  = ppu_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_INDEX_BITS = ppu_pkg::MAX_INDEX_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ppu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire ppu_pkg::ppu_cmd_t                cmd_i,
  output ppu_pkg::ppu_stat_t                    stat_o,
  input  wire logic [7:0]                       entry_index_i,
  input  wire logic [ppu_pkg::COMP_W-1:0]       entry_alpha_i,
  input  wire logic [ppu_pkg::COMP_W-1:0]       entry_red_i,
  input  wire logic [ppu_pkg::COMP_W-1:0]       entry_green_i,
  input  wire logic [ppu_pkg::COMP_W-1:0]       entry_blue_i,
  input  wire logic [7:0]                       data_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ppu_pkg::COMP_W-1:0]            pix_red_o,
  output logic [ppu_pkg::COMP_W-1:0]            pix_green_o,
  output logic [ppu_pkg::COMP_W-1:0]            pix_blue_o,
  output logic [ppu_pkg::COMP_W-1:0]            pix_alpha_o,
  output logic                                  last_of_byte_o
);
  import ppu_pkg::*;

  localparam int unsigned AW    = $clog2(PALETTE_DEPTH);
  localparam int unsigned ACC_W = (MAX_INDEX_BITS > 1) ? MAX_INDEX_BITS : 2;
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(PALETTE_DEPTH);
  localparam logic [BPP_W-1:0] BPP_MAX   = BPP_W'(MAX_INDEX_BITS);

  logic [BPP_W-1:0]   bpp_q;
  logic [COUNT_W-1:0] count_q;
  logic [FRAME_W-1:0] frame_q;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [FRAME_W-1:0] done_q, done_d;
  logic [7:0]         byte_q;

  logic [31:0]        mem [PALETTE_DEPTH];
  logic [31:0]        rdata_q;
  logic               black_q, last_q, out_valid_q, out_valid_d;

  logic [BPP_W-1:0]   bpp_eff;
  logic [ACC_W-1:0]   mask, acc_new, idx;
  logic [PEND_W-1:0]  pend_new;
  logic [FRAME_W-1:0] done_inc;
  logic [EXT_W-1:0]   idx_ext, wr_ext;
  logic               hit, black, last, emit, wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BPP_RESET;
      count_q <= '0;
      frame_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:   bpp_q   <= cfg_data_i[BPP_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_FRAME: frame_q <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_q > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = bpp_q;
    end
    for (int i = 0; i < ACC_W; i++) begin
      mask[i] = (BPP_W'(i) < bpp_eff);
    end
  end

  always_comb begin
    acc_new  = {acc_q[ACC_W-2:0], byte_q[cmd_i.bit_idx]};
    pend_new = (pend_q < PEND_MAX) ? pend_q + 1'b1 : pend_q;
    hit      = (pend_new >= bpp_eff);
    idx      = acc_new & mask;
    idx_ext  = EXT_W'(idx);
    black    = !((idx_ext < EXT_W'(count_q)) && (idx_ext < DEPTH_EXT));
    done_inc = done_q + 1'b1;
    last     = !((BPP_W'(cmd_i.bit_idx) >= bpp_eff) && (done_inc < frame_q));
    emit     = cmd_i.step && hit;

    acc_d  = acc_q;
    pend_d = pend_q;
    done_d = done_q;
    if (cmd_i.step) begin
      if (hit) begin
        acc_d  = '0;
        pend_d = '0;
        done_d = done_inc;
      end else begin
        acc_d  = acc_new;
        pend_d = pend_new;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= data_byte_i;
    end
    if (emit) begin
      black_q <= black;
      last_q  <= last;
    end
  end

  // palette memory, one write and one registered read port
  assign wr_ext = EXT_W'(entry_index_i);
  assign wr_en  = cmd_i.wr_pal && (wr_ext < DEPTH_EXT);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ext[AW-1:0]] <= {entry_alpha_i, entry_red_i, entry_green_i, entry_blue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rdata_q <= mem[idx_ext[AW-1:0]];
    end
  end

  assign stat_o.frame_done = (done_q >= frame_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pix_alpha_o    = black_q ? ALPHA_OPAQUE : rdata_q[31:24];
  assign pix_red_o      = black_q ? '0 : rdata_q[23:16];
  assign pix_green_o    = black_q ? '0 : rdata_q[15:8];
  assign pix_blue_o     = black_q ? '0 : rdata_q[7:0];
  assign last_of_byte_o = last_q;

endmodule
`default_nettype wire

// ===== rtl/palette_pixel_unpacker_top.sv =====
// Palette pixel unpacker: top level joining controller and datapath.
//
// Input channel (in_valid_i / in_stall_o) takes one beat per item: a palette
// write (req_type_i = 0) stores one ARGB entry; a data byte (req_type_i = 1) is
// unpacked one bit per cycle while the output is free, most significant first.
// A data byte keeps the input stalled until the serial bit step has taken its
// bits; the stall ends early once the frame pixel count is met and stretches
// while the output stalls. Each completed index reads the palette memory (one
// registered read port) and lands in the output register in the next cycle,
// so at one bit per pixel a byte gives up to eight pixel beats, on consecutive
// cycles while the output does not stall.
// Output channel (out_valid_o / out_stall_i): a stalled pixel holds, and the
// bit step pauses until the output register can take the next pixel. The
// next input beat is accepted while the last pixel still waits.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect in the next cycle.
// Reset clears the accumulator, pixel count and config to defaults
// (8 bits per pixel, no palette entries, empty frame); palette contents
// are undefined until written.
`default_nettype none
module palette_pixel_unpacker_top #(
  parameter int unsigned PALETTE_DEPTH  = ppu_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_INDEX_BITS = ppu_pkg::MAX_INDEX_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [7:0]                     entry_index_i,
  input  wire logic [7:0]                     entry_alpha_i,
  input  wire logic [7:0]                     entry_red_i,
  input  wire logic [7:0]                     entry_green_i,
  input  wire logic [7:0]                     entry_blue_i,
  input  wire logic [7:0]                     data_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          pix_red_o,
  output logic [7:0]                          pix_green_o,
  output logic [7:0]                          pix_blue_o,
  output logic [7:0]                          pix_alpha_o,
  output logic                                last_of_byte_o
);
  import ppu_pkg::*;

  ppu_cmd_t  cmd;
  ppu_stat_t stat;

  ppu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppu_datapath #(
    .PALETTE_DEPTH  (PALETTE_DEPTH),
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .entry_index_i  (entry_index_i),
    .entry_alpha_i  (entry_alpha_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pix_red_o      (pix_red_o),
    .pix_green_o    (pix_green_o),
    .pix_blue_o     (pix_blue_o),
    .pix_alpha_o    (pix_alpha_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule
`default_nettype wire

// ===== bench/palette_pixel_unpacker_top_tb.sv =====
// Self-checking testbench for palette_pixel_unpacker_top: random and directed beats, pixel checks.
`timescale 1ns / 1ps
module palette_pixel_unpacker_top_tb;
  import ppu_pkg::*;

  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned HOLD_CYC    = 150;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BEATS = 9;
  localparam logic [23:0] FRAME_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] data_byte;
  } beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pix_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i = REQ_PALETTE;
  logic [7:0]            entry_index_i = '0;
  logic [7:0]            entry_alpha_i = '0;
  logic [7:0]            entry_red_i = '0;
  logic [7:0]            entry_green_i = '0;
  logic [7:0]            entry_blue_i = '0;
  logic [7:0]            data_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            pix_red_o;
  logic [7:0]            pix_green_o;
  logic [7:0]            pix_blue_o;
  logic [7:0]            pix_alpha_o;
  logic                  last_of_byte_o;

  palette_pixel_unpacker_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [31:0] pal_model [256];
  logic [15:0] bit_acc = '0;
  logic [4:0]  bits_held = '0;
  logic [23:0] pix_done = '0;
  logic [4:0]  cfg_bpp = BPP_RESET;
  logic [8:0]  cfg_count = '0;
  logic [23:0] cfg_frame = '0;

  bit          entry_written [256];
  beat_t       beat_q [$];
  pix_t        expected_pix_q [$];
  beat_t       cur_beat;
  bit          beat_live = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 47;
  int unsigned quiet_cyc = 0;
  int unsigned pix_seen = 0;
  int unsigned err_cnt = 0;

  function automatic int unsigned index_width();
    if (cfg_bpp == 0) return 1;
    if (cfg_bpp > MAX_INDEX_BITS_DEF) return MAX_INDEX_BITS_DEF;
    return cfg_bpp;
  endfunction

  function automatic void decode_data_byte(input logic [7:0] byte_in);
    int unsigned bpp;
    logic [15:0] mask;
    logic [15:0] idx;
    logic [31:0] argb;
    pix_t        px;
    bit          have_px;
    bpp = index_width();
    mask = 16'((32'd1 << bpp) - 1);
    have_px = 1'b0;
    px = '0;
    for (int k = 7; k >= 0; k--) begin
      if (pix_done >= cfg_frame) break;
      bit_acc = {bit_acc[14:0], byte_in[k]};
      if (bits_held < PEND_MAX) bits_held = bits_held + 1'b1;
      if (bits_held >= bpp) begin
        idx = bit_acc & mask;
        bits_held = '0;
        bit_acc = '0;
        if (idx < cfg_count && idx < 16'd256) argb = pal_model[idx[7:0]];
        else argb = {ALPHA_OPAQUE, 24'h0};
        if (have_px) expected_pix_q.insert(expected_pix_q.size(), px);
        px = '{red: argb[23:16], green: argb[15:8], blue: argb[7:0], alpha: argb[31:24],
               last: 1'b0};
        have_px = 1'b1;
        pix_done = pix_done + 1'b1;
      end
    end
    if (have_px) begin
      px.last = 1'b1;
      expected_pix_q.insert(expected_pix_q.size(), px);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: pixel %0d %s: expected %0h, got %0h", $time, pix_seen, what, want, got);
    err_cnt++;
  endtask

  task automatic check_pixel();
    pix_t got;
    pix_t want;
    got = '{red: pix_red_o, green: pix_green_o, blue: pix_blue_o, alpha: pix_alpha_o,
            last: last_of_byte_o};
    if (expected_pix_q.size() == 0) begin
      flag_mismatch("with nothing expected", '0, {got.alpha, got.red, got.green, got.blue});
    end else begin
      want = expected_pix_q.pop_front();
      if (got.red !== want.red) flag_mismatch("red", want.red, got.red);
      if (got.green !== want.green) flag_mismatch("green", want.green, got.green);
      if (got.blue !== want.blue) flag_mismatch("blue", want.blue, got.blue);
      if (got.alpha !== want.alpha) flag_mismatch("alpha", want.alpha, got.alpha);
      if (got.last !== want.last) flag_mismatch("last_of_byte", want.last, got.last);
    end
    pix_seen++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_beat.req_type == REQ_PALETTE)
          pal_model[cur_beat.entry_index] = {cur_beat.alpha, cur_beat.red, cur_beat.green,
                                             cur_beat.blue};
        else
          decode_data_byte(cur_beat.data_byte);
        beat_live = 1'b0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = beat_q.pop_front();
          beat_live = 1'b1;
          in_valid_i <= 1'b1;
          req_type_i <= cur_beat.req_type;
          entry_index_i <= cur_beat.entry_index;
          entry_alpha_i <= cur_beat.alpha;
          entry_red_i <= cur_beat.red;
          entry_green_i <= cur_beat.green;
          entry_blue_i <= cur_beat.blue;
          data_byte_i <= cur_beat.data_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_pixel();
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni)
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= QUIET_LIMIT) begin
      $display("** palette_pixel_unpacker_top: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (beat_q.size() != 0 || beat_live || expected_pix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] keep;
    wait_drained();
    case (idx)
      CFG_BPP: begin
        keep = 24'h00001F;
        cfg_bpp = val[4:0];
      end
      CFG_COUNT: begin
        keep = 24'h0001FF;
        cfg_count = val[8:0];
      end
      default: begin
        keep = 24'hFFFFFF;
        cfg_frame = val;
      end
    endcase
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= (val & keep) | (24'($urandom()) & ~keep);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_palette(input logic [7:0] entry, input logic [31:0] argb);
    beat_t b;
    b = beat_t'({$urandom(), $urandom()});
    b.req_type = REQ_PALETTE;
    b.entry_index = entry;
    {b.alpha, b.red, b.green, b.blue} = argb;
    entry_written[entry] = 1'b1;
    beat_q.insert(beat_q.size(), b);
  endtask

  task automatic queue_byte(input logic [7:0] value);
    beat_t b;
    b = beat_t'({$urandom(), $urandom()});
    b.req_type = REQ_DATA;
    b.data_byte = value;
    beat_q.insert(beat_q.size(), b);
  endtask

  // every entry a data index can reach must hold a written value
  task automatic fill_reachable();
    int unsigned lim;
    lim = 32'd1 << index_width();
    if (cfg_count < lim) lim = cfg_count;
    if (lim > 256) lim = 256;
    for (int e = 0; e < lim; e++)
      if (!entry_written[e]) queue_palette(8'(e), $urandom());
  endtask

  initial begin
    int unsigned bpp_plan [PHASES];
    int unsigned count_plan [PHASES];
    logic [7:0]  pick;
    bpp_plan   = '{1, 4, 8, 12, 16, 2, 0, 31, 5, 9};
    count_plan = '{2, 16, 256, 256, 300, 511, 0, 100, 32, 256};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    queue_byte(8'hA5);
    write_reg(CFG_FRAME, 24'd1000);
    queue_byte(8'hFF);
    write_reg(CFG_COUNT, 24'd4);
    queue_palette(8'd0, 32'h00000000);
    queue_palette(8'd1, 32'hFFFFFFFF);
    queue_palette(8'd2, 32'h80FF00FF);
    queue_palette(8'd3, 32'h7F00FF00);
    queue_palette(8'd255, 32'h5AA55AA5);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_byte(8'h03);
    queue_byte(8'h04);
    write_reg(CFG_BPP, 24'd1);
    queue_byte(8'hA5);
    write_reg(CFG_BPP, 24'd3);
    queue_byte(8'h5A);
    queue_byte(8'hC3);
    queue_byte(8'h0F);
    write_reg(CFG_BPP, 24'd16);
    queue_byte(8'h00);
    queue_byte(8'h02);
    queue_byte(8'hFF);
    // lowered while eight bits are held
    write_reg(CFG_BPP, 24'd2);
    queue_byte(8'h96);
    write_reg(CFG_BPP, 24'd0);
    queue_byte(8'h3C);
    write_reg(CFG_BPP, 24'd31);
    queue_byte(8'h12);
    queue_byte(8'h01);
    write_reg(CFG_BPP, 24'd1);
    write_reg(CFG_FRAME, pix_done + 24'd3);
    queue_byte(8'hF0);
    queue_byte(8'h0F);
    write_reg(CFG_FRAME, 24'd2);
    queue_byte(8'h77);

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 22;
      end
      if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_BPP, 24'(bpp_plan[p]));
      write_reg(CFG_COUNT, 24'(count_plan[p]));
      if (p == 3 || p == 8) write_reg(CFG_FRAME, pix_done + 24'($urandom_range(4, 20)));
      else write_reg(CFG_FRAME, FRAME_MAX);
      fill_reachable();
      if (p == 1 || p == 5) hold_req = 1'b1;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if ($urandom_range(99) < 20) begin
          queue_palette(8'($urandom_range(255)), $urandom());
        end else begin
          case ($urandom_range(9))
            0:       pick = 8'h00;
            1:       pick = 8'hFF;
            default: pick = 8'($urandom_range(255));
          endcase
          queue_byte(pick);
        end
      end
    end

    wait_drained();
    if (expected_pix_q.size() != 0)
      flag_mismatch("left undelivered", '0, expected_pix_q.size());
    if (err_cnt == 0)
      $display("** palette_pixel_unpacker_top: PASSED **");
    else
      $display("** palette_pixel_unpacker_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppu_pkg.sv
rtl/ppu_ctrl.sv
rtl/ppu_datapath.sv
rtl/palette_pixel_unpacker_top.sv
bench/palette_pixel_unpacker_top_tb.sv
